/* hw/rtl/bc4e_pkg.sv */
// Shared types, codes and constants of the single-channel 4x4 block encoder.
package bc4e_pkg;

	// Texels in one 4x4 block, and the widths that follow from it.
	localparam int TEXELS = 16;
	localparam int TEX_AW = 4;
	localparam int IDX_W  = 3;
	localparam int BITS_W = TEXELS * IDX_W;

	// Palette entries and the interpolation step counter range.
	localparam int PAL_N = 8;
	localparam logic [IDX_W-1:0] PAL_FIRST = 3'd2;
	localparam logic [IDX_W-1:0] PAL_LAST  = 3'd7;
	localparam logic [IDX_W-1:0] PAL_ZERO  = 3'd6;

	// Numerator width: the largest is 6*255+254+3.
	localparam int NUM_W = 11;

	// Reciprocals for division by 7 and by 5 on numerators below 2048.
	localparam int RCP_W = 12;
	localparam logic [RCP_W-1:0] RECIP7 = 12'd2341;
	localparam int SHIFT7 = 14;
	localparam logic [RCP_W-1:0] RECIP5 = 12'd1639;
	localparam int SHIFT5 = 13;
	localparam int PROD_W = NUM_W + RCP_W;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2,
		CH_ALPHA = 2'd3
	} ch_sel_t;

	typedef enum logic [1:0] {
		BK_LOAD,
		BK_PAL,
		BK_INDEX
	} back_state_t;

	// One classified texel request travelling from front to back.
	typedef struct packed {
		logic [7:0]        value;
		logic [TEX_AW-1:0] pos;
		logic              last;
		logic [7:0]        lo;
		logic [7:0]        hi;
	} q_entry_t;

endpackage

/* hw/rtl/bc4e_front.sv */
// Front end: channel selection, texel position and running min/max tracking.
module bc4e_front
	import bc4e_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	input  logic      q_full,
	output logic      q_push,
	output q_entry_t  q_data
);

	ch_sel_t           chan_q;
	logic [TEX_AW-1:0] count_q;
	logic [7:0]        min_q;
	logic [7:0]        max_q;
	logic [7:0]        value;
	logic [7:0]        min_nx;
	logic [7:0]        max_nx;
	logic              last;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		unique case (chan_q)
			CH_RED:   value = red;
			CH_GREEN: value = green;
			CH_BLUE:  value = blue;
			CH_ALPHA: value = alpha;
			default:  value = alpha;
		endcase
	end

	assign min_nx = (value < min_q) ? value : min_q;
	assign max_nx = (value > max_q) ? value : max_q;
	assign last   = (count_q == TEX_AW'(TEXELS - 1));

	assign q_data.value = value;
	assign q_data.pos   = count_q;
	assign q_data.last  = last;
	assign q_data.lo    = min_nx;
	assign q_data.hi    = max_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q  <= CH_ALPHA;
			count_q <= '0;
			min_q   <= 8'hFF;
			max_q   <= 8'h00;
		end else begin
			if (cfg_we) begin
				chan_q <= ch_sel_t'(cfg_wdata);
			end
			if (q_push) begin
				if (last) begin
					count_q <= '0;
					min_q   <= 8'hFF;
					max_q   <= 8'h00;
				end else begin
					count_q <= count_q + TEX_AW'(1);
					min_q   <= min_nx;
					max_q   <= max_nx;
				end
			end
		end
	end

endmodule

/* hw/rtl/bc4e_fifo.sv */
// Short request queue between the front end and the back end.
module bc4e_fifo
	import bc4e_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output q_entry_t pop_data,
	output logic     not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t         slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hw/rtl/bc4e_back.sv */
// Back end: texel store, palette build and per-texel nearest-entry search.
module bc4e_back
	import bc4e_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  q_entry_t          q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        endpoint_max,
	output logic [7:0]        endpoint_min,
	output logic [BITS_W-1:0] index_bits
);

	back_state_t       state_q;
	back_state_t       state_nx;
	logic [7:0]        store_q [TEXELS];
	logic [7:0]        cur_q;
	logic [7:0]        hi_q;
	logic [7:0]        lo_q;
	logic              mode7_q;
	logic [NUM_W-1:0]  num_q;
	logic [IDX_W-1:0]  k_q;
	logic [7:0]        pal_q [PAL_N];
	logic [TEX_AW-1:0] j_q;
	logic [BITS_W-1:0] idx_q;
	logic              res_valid_q;
	logic [7:0]        res_max_q;
	logic [7:0]        res_min_q;
	logic [BITS_W-1:0] res_bits_q;

	logic [PROD_W-1:0] prod;
	logic [7:0]        quot;
	logic [7:0]        pal_val;
	logic [TEX_AW-1:0] rd_addr;
	logic [IDX_W-1:0]  sel;
	logic [NUM_W-1:0]  num_init;
	logic              out_free;
	logic              last_texel;
	logic              idx_step;
	logic              load_done;
	logic              pal_done;

	// Interpolated entry: numerator times the reciprocal of 7 or 5.
	assign prod = PROD_W'(num_q) * PROD_W'(mode7_q ? RECIP7 : RECIP5);
	assign quot = mode7_q ? 8'(prod >> SHIFT7) : 8'(prod >> SHIFT5);

	always_comb begin
		pal_val = quot;
		if (!mode7_q && (k_q >= PAL_ZERO)) begin
			pal_val = (k_q == PAL_ZERO) ? 8'h00 : 8'hFF;
		end
	end

	// First numerator of the sequence; later ones step by (lo - hi).
	always_comb begin
		if (q_data.hi > q_data.lo) begin
			num_init = (NUM_W'(q_data.hi) << 2) + (NUM_W'(q_data.hi) << 1)
				+ NUM_W'(q_data.lo) + NUM_W'(3);
		end else begin
			num_init = (NUM_W'(q_data.hi) << 2) + NUM_W'(q_data.lo) + NUM_W'(2);
		end
	end

	// The store is read one texel ahead: texel 0 on the last palette cycle,
	// then the next texel on every search step.
	assign rd_addr = pal_done ? '0 : j_q + TEX_AW'(1);

	// Nearest palette entry; strict compare keeps the lower index on ties.
	always_comb begin
		logic [7:0] best_d;
		logic [7:0] d;
		best_d = 8'hFF;
		sel    = '0;
		for (int k = 0; k < PAL_N; k++) begin
			d = (cur_q >= pal_q[k]) ? (cur_q - pal_q[k]) : (pal_q[k] - cur_q);
			if ((k == 0) || (d < best_d)) begin
				best_d = d;
				sel    = IDX_W'(k);
			end
		end
	end

	assign out_free   = !res_valid_q || !out_stall;
	assign last_texel = (j_q == TEX_AW'(TEXELS - 1));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_LOAD: begin
				if (q_valid && q_data.last) begin
					state_nx = BK_PAL;
				end
			end
			BK_PAL: begin
				if (k_q == PAL_LAST) begin
					state_nx = BK_INDEX;
				end
			end
			BK_INDEX: begin
				if (last_texel && out_free) begin
					state_nx = BK_LOAD;
				end
			end
			default: state_nx = BK_LOAD;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		load_done = 1'b0;
		pal_done  = 1'b0;
		idx_step  = 1'b0;
		unique case (state_q)
			BK_LOAD: begin
				q_pop     = q_valid;
				load_done = q_valid && q_data.last;
			end
			BK_PAL: begin
				pal_done = (k_q == PAL_LAST);
			end
			BK_INDEX: begin
				idx_step = !last_texel || out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			store_q[q_data.pos] <= q_data.value;
		end
		if (pal_done || idx_step) begin
			cur_q <= store_q[rd_addr];
		end
		if (load_done) begin
			hi_q     <= q_data.hi;
			lo_q     <= q_data.lo;
			mode7_q  <= (q_data.hi > q_data.lo);
			num_q    <= num_init;
			pal_q[0] <= q_data.hi;
			pal_q[1] <= q_data.lo;
		end
		if (state_q == BK_PAL) begin
			pal_q[k_q] <= pal_val;
			num_q      <= num_q - NUM_W'(hi_q) + NUM_W'(lo_q);
		end
		if (idx_step) begin
			idx_q <= {sel, idx_q[BITS_W-1:IDX_W]};
		end
		if (idx_step && last_texel) begin
			res_max_q  <= hi_q;
			res_min_q  <= lo_q;
			res_bits_q <= {sel, idx_q[BITS_W-1:IDX_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_LOAD;
			k_q         <= PAL_FIRST;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_done || pal_done) begin
				k_q <= PAL_FIRST;
			end else if (state_q == BK_PAL) begin
				k_q <= k_q + IDX_W'(1);
			end
			if (idx_step) begin
				j_q <= last_texel ? '0 : j_q + TEX_AW'(1);
			end
			if (idx_step && last_texel) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = res_valid_q;
	assign endpoint_max = res_max_q;
	assign endpoint_min = res_min_q;
	assign index_bits   = res_bits_q;

endmodule

/* hw/rtl/bc4_channel_block_encoder.sv */
// The result follows the sixteenth texel through its pop from the queue (behind any requests
// queued ahead of that texel), six palette entries and sixteen searches.
// Per block: 16 loads, six palette entries from one shared reciprocal multiplier and 16
// searches; the front takes a texel a cycle until the queue is full.
// Reset (arst_n low) clears counters, running min/max to 255/0, channel select to alpha,
// the queue and the output valid; the texel store and palette need no reset.
module bc4_channel_block_encoder
	import bc4e_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic [7:0]        alpha,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        endpoint_max,
	output logic [7:0]        endpoint_min,
	output logic [BITS_W-1:0] index_bits
);

	// Classified texel requests: channel value, block position, and the
	// endpoints as they stand after this texel (final on the last one).
	q_entry_t push_data;
	q_entry_t pop_data;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_not_empty;

	// The front end samples each texel with the channel select in force at
	// its own request, so a register write mid-block affects later texels only.
	bc4e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	// The queue lets the front keep taking texels of the next block while
	// the back end is still building the palette and indices of this one.
	bc4e_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	// The back end holds the finished result in its own register, so it can
	// return to loading the next block while the result waits to be taken.
	bc4e_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_data       (pop_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.endpoint_max (endpoint_max),
		.endpoint_min (endpoint_min),
		.index_bits   (index_bits)
	);

`ifndef SYNTHESIS
	// The endpoints are the block maximum and minimum, so they never cross.
	a_endpoint_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (endpoint_max >= endpoint_min))
		else $error("endpoint_max below endpoint_min");

	// Equal endpoints mean every texel equals them, which is palette entry 0.
	a_flat_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (endpoint_max == endpoint_min)) |-> (index_bits == '0))
		else $error("flat block with nonzero indices");

	// The back end only takes requests that the queue holds.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("queue popped while empty");
`endif

endmodule
